### hdl/tbc_pkg.sv
// shared types, constants and the controller/datapath command and status bundles
// for the tile map box collision unit; no dependencies
package tbc_pkg;

	localparam int TILE_W    = 8;
	localparam int TILE_H    = 8;
	localparam int MAP_BYTES = 1024;
	localparam int ADDR_W    = $clog2(MAP_BYTES);

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_TEST  = 2'd1;
	localparam logic [1:0] FUNC_MOVE  = 2'd2;

	localparam logic REG_MAP_COLUMNS = 1'b0;
	localparam logic REG_MAP_ROWS    = 1'b1;

	localparam logic [7:0] COLUMNS_RESET = 8'd128;
	localparam logic [4:0] ROWS_RESET    = 5'd8;

	localparam logic [1:0] TILE_MASK = 2'h3;

	typedef struct packed {
		logic [1:0]        func;
		logic [9:0]        write_addr;
		logic [7:0]        write_data;
		logic signed [11:0] pos_x;
		logic signed [7:0] pos_y;
		logic signed [7:0] move_dy;
		logic signed [7:0] box_off_x;
		logic signed [7:0] box_off_y;
		logic [6:0]        box_width;
		logic [6:0]        box_height;
	} tbc_in_t;

	typedef struct packed {
		logic              hit;
		logic signed [7:0] new_y;
	} tbc_out_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic span;
		logic next_tile;
		logic set_hit;
		logic advance;
		logic out_load;
	} tbc_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       dy_zero;
		logic       dy_last;
		logic       neg_x;
		logic       miss;
		logic       tile_hit;
		logic       tile_last;
	} tbc_sts_t;

endpackage

### hdl/tbc_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module tbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/tbc_datapath.sv
// datapath: operand, span and scan registers, map configuration, tile store
// depends on tbc_pkg and tbc_ram
module tbc_datapath import tbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tbc_in_t  in_data,
	input  logic     cfg_we,
	input  logic     cfg_index,
	input  logic [7:0] cfg_data,
	input  tbc_cmd_t cmd,
	output tbc_sts_t sts,
	output tbc_out_t out_data
);

	logic [7:0] cols_q;
	logic [4:0] rows_q;

	logic [1:0]         func_q;
	logic signed [11:0] px_q;
	logic signed [7:0]  ox_q, oy_q, dy_q, ny_q, cand_q;
	logic [6:0]         bw_q, bh_q;
	logic               hit_q;

	logic signed [13:0] x_q, xe_q;
	logic signed [7:0]  y_q;
	logic signed [9:0]  ye_q;

	logic [8:0]  ix_q, tx2_q;
	logic [4:0]  iy_q, ty1_q, ty2_q;
	logic [13:0] base_q, lin_q;
	logic        miss_q;

	logic [7:0] rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_COLUMNS: cols_q <= cfg_data;
				REG_MAP_ROWS:    rows_q <= cfg_data[4:0];
				default:         cols_q <= cols_q;
			endcase
		end
	end

	// tile store
	tbc_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_ram (
		.clk  (clk),
		.we   (cmd.load && in_data.func == FUNC_WRITE),
		.waddr(in_data.write_addr[ADDR_W-1:0]),
		.wdata(in_data.write_data),
		.raddr(lin_q[ADDR_W+1:2]),
		.rdata(rdata)
	);

	// operand setup
	logic signed [7:0]  in_step, step;
	logic signed [13:0] x_c;
	logic signed [7:0]  y_c;

	assign in_step = in_data.move_dy[7] ? -8'sd1 : 8'sd1;
	assign step    = dy_q[7] ? -8'sd1 : 8'sd1;
	assign x_c     = 14'(px_q) - 14'(ox_q);
	assign y_c     = cand_q - oy_q;

	// tile span
	logic signed [13:0] xl_c;
	logic signed [9:0]  yl_c, tx2raw_c, cols_m1_c, tx2c_c;
	logic signed [6:0]  ty2_c, ty1raw_c;
	logic [8:0]         tx1_c;
	logic [4:0]         ty1_c;
	logic [13:0]        base_c;
	logic               miss_c;

	assign xl_c      = xe_q - 14'sd1;
	assign yl_c      = ye_q - 10'sd1;
	assign tx1_c     = 9'(x_q / TILE_W);
	assign tx2raw_c  = 10'(xl_c / TILE_W);
	assign cols_m1_c = $signed({2'b00, cols_q}) - 10'sd1;
	assign tx2c_c    = (tx2raw_c > cols_m1_c) ? cols_m1_c : tx2raw_c;
	assign ty2_c     = 7'(yl_c / TILE_H);
	assign ty1raw_c  = 7'(y_q / TILE_H);
	assign ty1_c     = ty1raw_c[6] ? 5'd0 : ty1raw_c[4:0];
	assign base_c    = 14'(tx1_c * rows_q);
	// bottom row off the map, or an empty span after clamping
	assign miss_c    = ty2_c[6] || (ty2_c >= $signed({2'b00, rows_q}))
		|| (tx2c_c < $signed({1'b0, tx1_c}))
		|| (ty2_c < $signed({2'b00, ty1_c}));

	// tile check
	logic [1:0]         tile_c;
	logic signed [15:0] tx_c, ty_c;

	assign tile_c = 2'(rdata >> {iy_q[1:0], 1'b0}) & TILE_MASK;
	assign tx_c   = 16'(int'(ix_q) * TILE_W);
	assign ty_c   = 16'(int'(iy_q) * TILE_H);

	assign sts.func      = func_q;
	assign sts.dy_zero   = (dy_q == 8'sd0);
	assign sts.dy_last   = (dy_q == 8'sd1) || (dy_q == -8'sd1);
	assign sts.neg_x     = x_q[13];
	assign sts.miss      = miss_q;
	assign sts.tile_hit  = tile_c[1]
		&& (tx_c + 16'(TILE_W) > 16'(x_q)) && (tx_c < 16'(xe_q))
		&& (ty_c + 16'(TILE_H) > 16'(y_q)) && (ty_c < 16'(ye_q));
	assign sts.tile_last = (ix_q == tx2_q) && (iy_q == ty2_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_data.func;
			px_q   <= in_data.pos_x;
			ox_q   <= in_data.box_off_x;
			oy_q   <= in_data.box_off_y;
			bw_q   <= in_data.box_width;
			bh_q   <= in_data.box_height;
			dy_q   <= in_data.move_dy;
			hit_q  <= 1'b0;
			ny_q   <= (in_data.func == FUNC_TEST || in_data.func == FUNC_MOVE)
				? in_data.pos_y : 8'sd0;
			cand_q <= (in_data.func == FUNC_MOVE) ? in_data.pos_y + in_step
				: in_data.pos_y;
		end
		if (cmd.setup) begin
			x_q  <= x_c;
			y_q  <= y_c;
			xe_q <= x_c + 14'($signed({1'b0, bw_q}));
			ye_q <= 10'(y_c) + 10'($signed({1'b0, bh_q}));
		end
		if (cmd.span) begin
			ix_q   <= tx1_c;
			tx2_q  <= tx2c_c[8:0];
			iy_q   <= ty1_c;
			ty1_q  <= ty1_c;
			ty2_q  <= ty2_c[4:0];
			base_q <= base_c;
			lin_q  <= base_c + 14'(ty1_c);
			miss_q <= miss_c;
		end
		if (cmd.next_tile) begin
			if (iy_q == ty2_q) begin
				ix_q   <= ix_q + 9'd1;
				iy_q   <= ty1_q;
				base_q <= base_q + 14'(rows_q);
				lin_q  <= base_q + 14'(rows_q) + 14'(ty1_q);
			end else begin
				iy_q  <= iy_q + 5'd1;
				lin_q <= lin_q + 14'd1;
			end
		end
		if (cmd.set_hit) begin
			hit_q <= 1'b1;
		end
		if (cmd.advance) begin
			ny_q   <= cand_q;
			dy_q   <= dy_q - step;
			cand_q <= cand_q + step;
		end
		if (cmd.out_load) begin
			out_data.hit   <= hit_q;
			out_data.new_y <= ny_q;
		end
	end

endmodule

### hdl/tbc_controller.sv
// controller state machine: sequences setup, tile scan and per-pixel steps
// depends on tbc_pkg
module tbc_controller import tbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  tbc_sts_t sts,
	output tbc_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE, DISPATCH, SETUP, SPAN, DECIDE, READ, CHECK, DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = DISPATCH;
				end
			end
			DISPATCH: begin
				if (sts.func == FUNC_TEST
						|| (sts.func == FUNC_MOVE && !sts.dy_zero)) begin
					state_d = SETUP;
				end else begin
					state_d = DONE;
				end
			end
			SETUP: begin
				cmd.setup = 1'b1;
				state_d   = SPAN;
			end
			SPAN: begin
				cmd.span = 1'b1;
				state_d  = DECIDE;
			end
			DECIDE: begin
				if (sts.neg_x) begin
					cmd.set_hit = 1'b1;
					state_d     = DONE;
				end else if (!sts.miss) begin
					state_d = READ;
				end else if (sts.func == FUNC_MOVE) begin
					cmd.advance = 1'b1;
					state_d     = sts.dy_last ? DONE : SETUP;
				end else begin
					state_d = DONE;
				end
			end
			READ: begin
				state_d = CHECK;
			end
			CHECK: begin
				if (sts.tile_hit) begin
					cmd.set_hit = 1'b1;
					state_d     = DONE;
				end else if (!sts.tile_last) begin
					cmd.next_tile = 1'b1;
					state_d       = READ;
				end else if (sts.func == FUNC_MOVE) begin
					cmd.advance = 1'b1;
					state_d     = sts.dy_last ? DONE : SETUP;
				end else begin
					state_d = DONE;
				end
			end
			DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DISPATCH && sts.func == FUNC_WRITE) |=> state_q == DONE)
		else $error("map write did not go straight to result");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == DONE))
		else $error("result raised outside done");
	a_scan_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == READ |-> !sts.miss && !sts.neg_x)
		else $error("tile read on a missed or negative box");

endmodule

### hdl/tilemap_box_collision_unit.sv
// top level of the tile map box collision unit
// depends on tbc_pkg, tbc_controller and tbc_datapath
//
// the unit holds a 1024-byte tile map, four 2-bit tiles a byte in column-major
// order, and answers one result per accepted item: func 0 writes a map byte,
// func 1 tests a hitbox against the map, func 2 moves y one pixel at a time
// and stops before the first colliding step. one item is worked on at a time;
// a finished result sits in an output register, so the next item can be taken
// while it waits. a write or unused func goes from dispatch straight to its
// result; a test sets up the box, finds its tile span and scans the span one
// tile at a time (scan stops on the first solid tile hit), and a move does
// the same for each pixel step. the scan visits the tiles through the single
// tile store read port, reading each tile and then checking it. map size
// registers (index 0 columns, index 1 rows) are written over the cfg channel,
// which is always ready; write them only while the unit is idle. map bytes
// never written read back as undefined. no clearing pass after reset.
module tilemap_box_collision_unit import tbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tbc_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output tbc_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_index,
	input  logic [7:0] cfg_data
);

	tbc_cmd_t cmd;
	tbc_sts_t sts;

	// config transfer is taken every cycle
	assign cfg_ready = 1'b1;

	// sequencing of load, span setup, scan and per-pixel steps
	tbc_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// operands, tile store and the output register
	tbc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
